### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define CHK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset
`define CHK_IMPLY(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

// Next-cycle implication checked outside reset
`define CHK_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

### design/lee_pkg.sv
`timescale 1ns / 1ps

package lee_pkg;

   // Line geometry
   localparam int LINE_MAX = 16;
   localparam int CNT_W    = $clog2(LINE_MAX + 1);
   localparam int IDX_W    = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

   // Input key codes
   localparam logic [7:0] K_ERASE = 8'd127;
   localparam logic [7:0] K_KILL  = 8'd21;
   localparam logic [7:0] K_WORD  = 8'd23;
   localparam logic [7:0] K_EOF   = 8'd4;
   localparam logic [7:0] K_SPACE = 8'd32;
   localparam logic [7:0] K_TILDE = 8'd126;

   // Echo characters
   localparam logic [7:0] CH_BS   = 8'd8;
   localparam logic [7:0] CH_SP   = 8'd32;
   localparam logic [7:0] CH_LF   = 8'd10;
   localparam logic [7:0] CH_BEL  = 8'd7;
   localparam logic [7:0] CH_CR   = 8'd13;
   localparam logic [7:0] CH_ESC  = 8'd27;
   localparam logic [7:0] CH_LBR  = 8'd91;
   localparam logic [7:0] CH_K    = 8'd75;

   // Class of the latched input byte
   typedef enum logic [2:0] {
      KIND_EOF,
      KIND_ERASE,
      KIND_KILL,
      KIND_WORD,
      KIND_PRINT,
      KIND_OTHER
   } kind_type;

   // Source of an echo word
   typedef enum logic [3:0] {
      SRC_BS,
      SRC_SP,
      SRC_LF,
      SRC_BEL,
      SRC_CR,
      SRC_ESC,
      SRC_LBR,
      SRC_K,
      SRC_IN,
      SRC_RD,
      SRC_END
   } src_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_ONE
   } cnt_op_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_CLR,
      IDX_INC
   } idx_op_type;

   // Controller to datapath
   typedef struct packed {
      logic       load;
      logic       wr_en;
      logic       wr_zero;
      logic       rd_en;
      logic       rd_top;
      cnt_op_type cnt_op;
      idx_op_type idx_op;
      logic       push;
      src_type    src;
      logic       last;
      logic       sess_end;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     cnt_zero;
      logic     cnt_one;
      logic     cnt_full;
      logic     rd_space;
      logic     idx_at_cnt;
      logic     out_free;
   } stat_type;

endpackage

### design/lee_datapath.sv
`timescale 1ns / 1ps

module lee_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        req_tdata,
   input  lee_pkg::cmd_type  cmd,
   output lee_pkg::stat_type st,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);
   import lee_pkg::*;

   logic [7:0]       byte_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_m1;
   logic [7:0]       line_mem [LINE_MAX];
   logic [7:0]       rd_data_ff;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff, out_end_ff;
   logic [7:0]       echo;
   kind_type         kind;

   // Latched input byte
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= req_tdata;
      end
   end

   // Byte classification
   always_comb begin
      kind = KIND_OTHER;
      if (byte_ff == K_EOF) begin
         kind = KIND_EOF;
      end else if (byte_ff == K_ERASE) begin
         kind = KIND_ERASE;
      end else if (byte_ff == K_KILL) begin
         kind = KIND_KILL;
      end else if (byte_ff == K_WORD) begin
         kind = KIND_WORD;
      end else if (byte_ff inside {[K_SPACE:K_TILDE]}) begin
         kind = KIND_PRINT;
      end
   end

   // Line length
   always_comb begin
      case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + CNT_W'(1);
         CNT_DEC: count_in = count_ff - CNT_W'(1);
         CNT_ONE: count_in = CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   // Reprint index
   always_comb begin
      case (cmd.idx_op)
         IDX_CLR: idx_in = '0;
         IDX_INC: idx_in = idx_ff + CNT_W'(1);
         default: idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   // Line store: one write port, one registered read port
   assign cnt_m1  = count_ff - CNT_W'(1);
   assign wr_addr = cmd.wr_zero ? '0 : count_ff[IDX_W-1:0];
   assign rd_addr = cmd.rd_top ? cnt_m1[IDX_W-1:0] : idx_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         line_mem[wr_addr] <= byte_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   // Echo byte select
   always_comb begin
      case (cmd.src)
         SRC_BS:  echo = CH_BS;
         SRC_SP:  echo = CH_SP;
         SRC_LF:  echo = CH_LF;
         SRC_BEL: echo = CH_BEL;
         SRC_CR:  echo = CH_CR;
         SRC_ESC: echo = CH_ESC;
         SRC_LBR: echo = CH_LBR;
         SRC_K:   echo = CH_K;
         SRC_IN:  echo = byte_ff;
         SRC_RD:  echo = rd_data_ff;
         default: echo = '0;
      endcase
   end

   // Output register
   assign out_valid_in = cmd.push | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_byte_ff <= echo;
         out_last_ff <= cmd.last;
         out_end_ff  <= cmd.sess_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_end_ff;

   // Status
   assign st.kind       = kind;
   assign st.cnt_zero   = (count_ff == '0);
   assign st.cnt_one    = (count_ff == CNT_W'(1));
   assign st.cnt_full   = (count_ff == CNT_W'(LINE_MAX));
   assign st.rd_space   = (rd_data_ff == K_SPACE);
   assign st.idx_at_cnt = (idx_ff == count_ff);
   assign st.out_free   = ~out_valid_ff | rsp_tready;

endmodule

### design/lee_ctrl.sv
`timescale 1ns / 1ps

module lee_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  lee_pkg::stat_type st,
   output lee_pkg::cmd_type  cmd
);
   import lee_pkg::*;

   typedef enum logic [15:0] {
      ST_IDLE = 16'h0001,
      ST_DISP = 16'h0002,
      ST_END  = 16'h0004,
      ST_BEL  = 16'h0008,
      ST_BS1  = 16'h0010,
      ST_SP   = 16'h0020,
      ST_BS2  = 16'h0040,
      ST_WRD  = 16'h0080,
      ST_WCHK = 16'h0100,
      ST_CR   = 16'h0200,
      ST_ESC  = 16'h0400,
      ST_LBR  = 16'h0800,
      ST_K    = 16'h1000,
      ST_PRT  = 16'h2000,
      ST_LF   = 16'h4000,
      ST_CHR  = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      kill_ff, kill_in;     // erase repeats until the line is empty
   logic      wphase_ff, wphase_in; // word-erase: past the trailing spaces

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         kill_ff   <= 1'b0;
         wphase_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         kill_ff   <= kill_in;
         wphase_ff <= wphase_in;
      end
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      kill_in    = kill_ff;
      wphase_in  = wphase_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.cnt_op = CNT_HOLD;
      cmd.idx_op = IDX_HOLD;
      cmd.src    = SRC_END;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load   = 1'b1;
               cmd.idx_op = IDX_CLR;
               kill_in    = 1'b0;
               wphase_in  = 1'b0;
               state_in   = ST_DISP;
            end
         end

         ST_DISP: begin
            case (st.kind)
               KIND_EOF:   state_in = st.cnt_zero ? ST_END : ST_BEL;
               KIND_ERASE: state_in = st.cnt_zero ? ST_IDLE : ST_BS1;
               KIND_KILL: begin
                  kill_in  = 1'b1;
                  state_in = st.cnt_zero ? ST_IDLE : ST_BS1;
               end
               KIND_WORD:  state_in = ST_WRD;
               KIND_PRINT: begin
                  cmd.wr_en = 1'b1;
                  if (st.cnt_full) begin
                     cmd.wr_zero = 1'b1;
                     cmd.cnt_op  = CNT_ONE;
                     state_in    = ST_LF;
                  end else begin
                     cmd.cnt_op  = CNT_INC;
                     state_in    = ST_CHR;
                  end
               end
               default:    state_in = ST_BEL;
            endcase
         end

         ST_END: begin
            if (st.out_free) begin
               cmd.push     = 1'b1;
               cmd.src      = SRC_END;
               cmd.last     = 1'b1;
               cmd.sess_end = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_BEL: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               cmd.src  = SRC_BEL;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end

         // BS SP BS, once for erase, per character for kill
         ST_BS1: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               cmd.src  = SRC_BS;
               state_in = ST_SP;
            end
         end

         ST_SP: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               cmd.src  = SRC_SP;
               state_in = ST_BS2;
            end
         end

         ST_BS2: begin
            if (st.out_free) begin
               cmd.push   = 1'b1;
               cmd.src    = SRC_BS;
               cmd.cnt_op = CNT_DEC;
               cmd.last   = ~kill_ff | st.cnt_one;
               state_in   = (kill_ff && !st.cnt_one) ? ST_BS1 : ST_IDLE;
            end
         end

         // Word-erase trim: fetch the last character, then test it
         ST_WRD: begin
            if (st.cnt_zero) begin
               state_in = ST_CR;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_top = 1'b1;
               state_in   = ST_WCHK;
            end
         end

         ST_WCHK: begin
            if (wphase_ff && st.rd_space) begin
               state_in = ST_CR;
            end else begin
               if (!st.rd_space) begin
                  wphase_in = 1'b1;
               end
               cmd.cnt_op = CNT_DEC;
               state_in   = ST_WRD;
            end
         end

         ST_CR: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               cmd.src  = SRC_CR;
               state_in = ST_ESC;
            end
         end

         ST_ESC: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               cmd.src  = SRC_ESC;
               state_in = ST_LBR;
            end
         end

         ST_LBR: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               cmd.src  = SRC_LBR;
               state_in = ST_K;
            end
         end

         // Last of the header; prefetch the first stored character
         ST_K: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               cmd.src  = SRC_K;
               cmd.last = st.cnt_zero;
               if (st.cnt_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.idx_op = IDX_INC;
                  state_in   = ST_PRT;
               end
            end
         end

         // Reprint: send one character while fetching the next
         ST_PRT: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               cmd.src  = SRC_RD;
               cmd.last = st.idx_at_cnt;
               if (st.idx_at_cnt) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.idx_op = IDX_INC;
               end
            end
         end

         ST_LF: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               cmd.src  = SRC_LF;
               state_in = ST_CHR;
            end
         end

         ST_CHR: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               cmd.src  = SRC_IN;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### design/line_edit_echo.sv
// Line editor with echo.
// req_ (stream in): one typed byte per word on req_tdata.
// rsp_ (stream out): the echo bytes for that input as a run of words;
//    rsp_tlast marks the final word of the run, rsp_tuser marks the
//    end-of-session word (Ctrl-D on an empty line, data 0).
// An input may cause no words (erase or kill on an empty line).
// Fixed sequences and the reprint after word-erase run at one word per
// cycle while the receiver keeps up; trimming during word-erase takes one
// store read and one test per removed character, and stops at the space
// in front of the word or on reaching an empty line.
// req_tready is high only between items.
// A stalled receiver holds the output register; the sequencer waits and
// nothing is lost. Reset empties the line and drops any pending word;
// the line store itself is not cleared.
`timescale 1ns / 1ps

module line_edit_echo (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] echo_byte
   output logic       rsp_tlast,
   output logic       rsp_tuser    // [0] session_end
);
   import lee_pkg::*;

   cmd_type  cmd;
   stat_type st;

   lee_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   lee_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .st         (st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`include "assert_macros.svh"

   // Session end is a lone zero word closing its run
   `CHK_IMPLY(a_end_word, rsp_tvalid && rsp_tuser, rsp_tlast && rsp_tdata == 8'd0, "bad end word")
   // Busy right after taking a word
   `CHK_NEXT(a_busy, req_tvalid && req_tready, !req_tready, "ready after accept")
   // Never load the output register while it still holds an untaken word
   `CHK_IMPLY(a_push_free, cmd.push, st.out_free, "push into full output")
   // A store write never lands past the end of the line
   `CHK_IMPLY(a_wr_range, cmd.wr_en, !st.cnt_full || cmd.wr_zero, "write past line end")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import lee_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_KEYS  = 165;
   localparam int HOLD_CYCLES  = 400;   // long receiver stall, fills the block
   localparam int DRAIN_CYCLES = 64;    // quiet time after the last expected word
   localparam int IDLE_LIMIT   = 3000;  // cycles with no word moving on either side
   localparam int BURST_SPAN   = 24;    // words per idle/burst decision

   // One echo word as seen on the result side
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       sess;
   } echo_type;

   // One row of the directed script; typed rows carry their own expectation
   typedef struct packed {
      logic [7:0] key;
      logic [4:0] reps;
      logic       typed;
      logic [1:0] n_words;
      echo_type   word;
   } key_row_type;

   localparam int N_ROWS = 22;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       rsp_tuser;

   // Shadow of the line editor
   logic [7:0]  line_buf [LINE_MAX];
   int unsigned line_len = 0;
   echo_type    key_run [$];
   echo_type    pending_echo [$];

   int errors       = 0;
   int stall_cycles = 0;
   int req_items    = 0;
   bit req_burst    = 1'b0;
   bit hold_req     = 1'b0;

   key_row_type key_script [N_ROWS] = '{
      // right after reset: end of session, then the empty-line cases
      '{K_EOF,   5'd1, 1'b1, 2'd1, '{8'd0,    1'b1, 1'b1}},
      '{K_ERASE, 5'd1, 1'b1, 2'd0, '{8'd0,    1'b0, 1'b0}},
      '{K_KILL,  5'd1, 1'b1, 2'd0, '{8'd0,    1'b0, 1'b0}},
      '{K_WORD,  5'd1, 1'b0, 2'd0, '{8'd0,    1'b0, 1'b0}},
      // printable extremes and non-printable bytes
      '{K_SPACE, 5'd1, 1'b1, 2'd1, '{K_SPACE, 1'b1, 1'b0}},
      '{K_TILDE, 5'd1, 1'b1, 2'd1, '{K_TILDE, 1'b1, 1'b0}},
      '{8'h00,   5'd1, 1'b1, 2'd1, '{CH_BEL,  1'b1, 1'b0}},
      '{8'hff,   5'd1, 1'b1, 2'd1, '{CH_BEL,  1'b1, 1'b0}},
      '{8'h80,   5'd1, 1'b1, 2'd1, '{CH_BEL,  1'b1, 1'b0}},
      // Ctrl-D with text on the line is just a bell
      '{K_EOF,   5'd1, 1'b1, 2'd1, '{CH_BEL,  1'b1, 1'b0}},
      '{K_ERASE, 5'd1, 1'b0, 2'd0, '{8'd0,    1'b0, 1'b0}},
      // word-erase over a lone space leaves an empty line
      '{K_WORD,  5'd1, 1'b0, 2'd0, '{8'd0,    1'b0, 1'b0}},
      // "a b " then word-erase: trailing space and "b" go, "a " reprinted
      '{"a",     5'd1, 1'b0, 2'd0, '{8'd0,    1'b0, 1'b0}},
      '{K_SPACE, 5'd1, 1'b0, 2'd0, '{8'd0,    1'b0, 1'b0}},
      '{"b",     5'd1, 1'b0, 2'd0, '{8'd0,    1'b0, 1'b0}},
      '{K_SPACE, 5'd1, 1'b0, 2'd0, '{8'd0,    1'b0, 1'b0}},
      '{K_WORD,  5'd1, 1'b0, 2'd0, '{8'd0,    1'b0, 1'b0}},
      // fill the line, then one more printable wraps to a new line
      '{"z",     5'(LINE_MAX - 2), 1'b0, 2'd0, '{8'd0, 1'b0, 1'b0}},
      '{"y",     5'd1, 1'b0, 2'd0, '{8'd0,    1'b0, 1'b0}},
      '{K_KILL,  5'd1, 1'b0, 2'd0, '{8'd0,    1'b0, 1'b0}},
      '{K_EOF,   5'd1, 1'b1, 2'd1, '{8'd0,    1'b1, 1'b1}},
      '{K_ERASE, 5'd1, 1'b1, 2'd0, '{8'd0,    1'b0, 1'b0}}
   };

   line_edit_echo u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic echo_type plain(input logic [7:0] ch);
      return '{ch, 1'b0, 1'b0};
   endfunction

   // Edit the shadow line for one key and build the echo run it causes
   function automatic void echo_for_key(input logic [7:0] key);
      key_run = {};
      if (key == K_EOF && line_len == 0) begin
         key_run.push_back('{8'd0, 1'b0, 1'b1});
      end else if (key == K_ERASE) begin
         if (line_len > 0) begin
            line_len--;
            key_run.push_back(plain(CH_BS));
            key_run.push_back(plain(CH_SP));
            key_run.push_back(plain(CH_BS));
         end
      end else if (key == K_KILL) begin
         while (line_len > 0) begin
            key_run.push_back(plain(CH_BS));
            key_run.push_back(plain(CH_SP));
            key_run.push_back(plain(CH_BS));
            line_len--;
         end
      end else if (key == K_WORD) begin
         // trailing blanks first, then the word before them
         while (line_len > 0 && line_buf[line_len - 1] == K_SPACE) line_len--;
         while (line_len > 0 && line_buf[line_len - 1] != K_SPACE) line_len--;
         key_run.push_back(plain(CH_CR));
         key_run.push_back(plain(CH_ESC));
         key_run.push_back(plain(CH_LBR));
         key_run.push_back(plain(CH_K));
         for (int i = 0; i < line_len; i++) key_run.push_back(plain(line_buf[i]));
      end else if (key >= K_SPACE && key <= K_TILDE) begin
         if (line_len < LINE_MAX) begin
            line_buf[line_len] = key;
            line_len++;
         end else begin
            // full line wraps: newline, then the key starts a fresh line
            key_run.push_back(plain(CH_LF));
            line_buf[0] = key;
            line_len = 1;
         end
         key_run.push_back(plain(key));
      end else begin
         key_run.push_back(plain(CH_BEL));
      end
      if (key_run.size() > 0) key_run[key_run.size() - 1].last = 1'b1;
   endfunction

   // Mostly typing and editing, with some raw bytes mixed in
   function automatic logic [7:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 48) return 8'($urandom_range(int'(K_SPACE) + 1, int'(K_TILDE)));
      if (roll < 62) return K_SPACE;
      if (roll < 70) return K_ERASE;
      if (roll < 75) return K_KILL;
      if (roll < 84) return K_WORD;
      if (roll < 88) return K_EOF;
      return 8'($urandom_range(0, 255));
   endfunction

   // Offer one key; returns at the edge where it is taken
   task automatic send_key(input logic [7:0] key, input logic typed,
                           input logic [1:0] n_words, input echo_type word);
      int gap;
      if (req_items % BURST_SPAN == 0) req_burst = ($urandom_range(0, 3) == 0);
      req_items++;
      gap = req_burst ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      echo_for_key(key);
      if (typed) begin
         for (int k = 0; k < n_words; k++) pending_echo.push_back(word);
      end else begin
         foreach (key_run[k]) pending_echo.push_back(key_run[k]);
      end
   endtask

   // Stimulus
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (key_script[r]) begin
         for (int k = 0; k < key_script[r].reps; k++) begin
            send_key(key_script[r].key, key_script[r].typed,
                     key_script[r].n_words, key_script[r].word);
         end
      end

      hold_req = 1'b1;
      for (int i = 0; i < RANDOM_KEYS; i++) begin
         // halfway: let the echo side drain completely
         if (i == RANDOM_KEYS / 2) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (pending_echo.size() != 0) @(negedge clock);
         end
         send_key(pick_key(), 1'b0, 2'd0, '0);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (pending_echo.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("line_edit_echo regression: pass");
      end else begin
         $display("line_edit_echo regression: fail");
      end
      $finish;
   end

   // Echo receiver with random stalls and one long hold
   initial begin
      int       gap;
      int       words;
      bit       burst;
      echo_type want;
      words = 0;
      burst = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (words % BURST_SPAN == 0) burst = ($urandom_range(0, 3) == 0);
         words++;
         gap = burst ? 0 : $urandom_range(0, 14);
         if (hold_req) begin
            hold_req = 1'b0;
            gap = HOLD_CYCLES;
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (pending_echo.size() == 0) begin
            errors++;
            $display("%0t: unexpected word data=%h last=%b end=%b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want = pending_echo.pop_front();
            if (rsp_tdata !== want.data) begin
               errors++;
               $display("%0t: echo_byte expected %h, got %h", $time, want.data, rsp_tdata);
            end
            if (rsp_tlast !== want.last) begin
               errors++;
               $display("%0t: last_of_run expected %b, got %b",
                        $time, want.last, rsp_tlast);
            end
            if (rsp_tuser !== want.sess) begin
               errors++;
               $display("%0t: session_end expected %b, got %b",
                        $time, want.sess, rsp_tuser);
            end
         end
      end
   end

   // Watchdog: too long with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= IDLE_LIMIT) begin
         $display("line_edit_echo regression: fail");
         $finish;
      end
   end

endmodule
